>>> hdl/stid_pkg.sv
`timescale 1ns / 1ps

package stid_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the request and response items
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Commands from the controller to the datapath
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_READ,
        CMD_SCAN_NEXT,
        CMD_SCAN_MISS,
        CMD_SCAN_STOP,
        CMD_FULL,
        CMD_MISS,
        CMD_FOUND,
        CMD_INS_START,
        CMD_INS_READ,
        CMD_INS_MOVE,
        CMD_INS_PUT,
        CMD_DEL_START,
        CMD_DEL_READ,
        CMD_DEL_MOVE,
        CMD_DEL_DROP,
        CMD_CLEAR,
        CMD_MIN_READ,
        CMD_MAX_READ,
        CMD_MAX_TAKE,
        CMD_EMPTY,
        CMD_PUBLISH
    } cmd_t;

    // Status from the datapath back to the controller
    typedef struct packed {
        op_t  op;
        logic at_end;
        logic less;
        logic full;
        logic at_pos;
        logic del_last;
        logic empty;
        logic hit;
    } dp_status_t;

endpackage

>>> hdl/stid_req_if.sv
`timescale 1ns / 1ps

interface stid_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [stid_pkg::OPCODE_W-1:0]   opcode;
    logic signed [stid_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> hdl/stid_rsp_if.sv
`timescale 1ns / 1ps

interface stid_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic        [stid_pkg::INDEX_W-1:0]    found_index;
    logic        [stid_pkg::STATUS_W-1:0]   status;
    logic        [stid_pkg::COUNT_W-1:0]    entry_count;
    logic signed [stid_pkg::VALUE_W-1:0]    min_value;
    logic signed [stid_pkg::VALUE_W-1:0]    max_value;

    modport source (output valid, output found_index, output status, output entry_count,
                    output min_value, output max_value, input ready);
    modport sink   (input valid, input found_index, input status, input entry_count,
                    input min_value, input max_value, output ready);
endinterface

>>> hdl/stid_ram.sv
`timescale 1ns / 1ps

module stid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/stid_datapath.sv
`timescale 1ns / 1ps

module stid_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stid_pkg::cmd_t                        cmd,
    input  logic        [stid_pkg::OPCODE_W-1:0]  in_opcode,
    input  logic signed [stid_pkg::VALUE_W-1:0]   in_value,
    output stid_pkg::dp_status_t                  sts,
    output logic        [stid_pkg::INDEX_W-1:0]   found_index,
    output logic        [stid_pkg::STATUS_W-1:0]  status,
    output logic        [stid_pkg::COUNT_W-1:0]   entry_count,
    output logic signed [stid_pkg::VALUE_W-1:0]   min_value,
    output logic signed [stid_pkg::VALUE_W-1:0]   max_value
);

    localparam int AW = stid_pkg::ADDR_W;
    localparam int CW = stid_pkg::CNT_W;
    localparam int VW = stid_pkg::VALUE_W;

    stid_pkg::op_t                  op_reg, op_next;
    logic signed [VW-1:0]           value_reg, value_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic                           hit_reg, hit_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [stid_pkg::STATUS_W-1:0]  stat_reg, stat_next;
    logic [CW-1:0]                  found_reg, found_next;
    logic signed [VW-1:0]           min_reg, min_next;
    logic signed [VW-1:0]           max_reg, max_next;

    logic [stid_pkg::INDEX_W-1:0]   out_found_reg, out_found_next;
    logic [stid_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [stid_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic signed [VW-1:0]           out_min_reg, out_min_next;
    logic signed [VW-1:0]           out_max_reg, out_max_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;
    logic [CW:0]   idx_plus_one;

    stid_ram #(
        .WIDTH (VW),
        .DEPTH (stid_pkg::CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_plus_one = (CW+1)'(idx_reg) + (CW+1)'(1);

    always_comb
    begin
        sts.op       = op_reg;
        sts.at_end   = (idx_reg == count_reg);
        sts.less     = ($signed(ram_rdata) < value_reg);
        sts.full     = (count_reg == CW'(stid_pkg::CAPACITY));
        sts.at_pos   = (idx_reg == pos_reg);
        sts.del_last = (idx_plus_one >= (CW+1)'(count_reg));
        sts.empty    = (count_reg == '0);
        sts.hit      = hit_reg;
    end

    always_comb
    begin
        op_next         = op_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[AW-1:0];

        unique case (cmd)
            stid_pkg::CMD_NONE:
            begin
            end
            stid_pkg::CMD_LOAD:
            begin
                op_next    = stid_pkg::op_t'(in_opcode);
                value_next = in_value;
                idx_next   = '0;
                stat_next  = stid_pkg::ST_DONE;
                found_next = '0;
            end
            stid_pkg::CMD_SCAN_READ:
            begin
                ram_re = 1'b1;
            end
            stid_pkg::CMD_SCAN_NEXT:
            begin
                idx_next = idx_reg + CW'(1);
            end
            stid_pkg::CMD_SCAN_MISS:
            begin
                pos_next = idx_reg;
                hit_next = 1'b0;
            end
            stid_pkg::CMD_SCAN_STOP:
            begin
                pos_next = idx_reg;
                hit_next = ($signed(ram_rdata) == value_reg);
            end
            stid_pkg::CMD_FULL:
            begin
                stat_next = stid_pkg::ST_FULL;
            end
            stid_pkg::CMD_MISS:
            begin
                stat_next = stid_pkg::ST_MISSING;
            end
            stid_pkg::CMD_FOUND:
            begin
                found_next = pos_reg + CW'(1);
            end
            stid_pkg::CMD_INS_START:
            begin
                idx_next = count_reg;
            end
            stid_pkg::CMD_INS_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_reg - CW'(1));
            end
            stid_pkg::CMD_INS_MOVE:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            stid_pkg::CMD_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = value_reg;
                count_next = count_reg + CW'(1);
            end
            stid_pkg::CMD_DEL_START:
            begin
                idx_next = pos_reg;
            end
            stid_pkg::CMD_DEL_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_plus_one);
            end
            stid_pkg::CMD_DEL_MOVE:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
            end
            stid_pkg::CMD_DEL_DROP:
            begin
                count_next = count_reg - CW'(1);
            end
            stid_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            stid_pkg::CMD_MIN_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            stid_pkg::CMD_MAX_READ:
            begin
                min_next  = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = AW'(count_reg - CW'(1));
            end
            stid_pkg::CMD_MAX_TAKE:
            begin
                max_next = ram_rdata;
            end
            stid_pkg::CMD_EMPTY:
            begin
                min_next = '0;
                max_next = '0;
            end
            stid_pkg::CMD_PUBLISH:
            begin
                out_found_next  = stid_pkg::INDEX_W'(found_reg);
                out_status_next = stat_reg;
                out_count_next  = stid_pkg::COUNT_W'(count_reg);
                out_min_next    = min_reg;
                out_max_next    = max_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        hit_reg        <= hit_next;
        stat_reg       <= stat_next;
        found_reg      <= found_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
    end

    assign found_index = out_found_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign min_value   = out_min_reg;
    assign max_value   = out_max_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(stid_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_ins_move_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == stid_pkg::CMD_INS_MOVE) |-> (idx_reg > pos_reg))
        else $error("insert shift reached the insert position");
`endif

endmodule

>>> hdl/stid_controller.sv
`timescale 1ns / 1ps

module stid_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  stid_pkg::dp_status_t sts,
    output stid_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ACT,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FIN,
        S_MAX_RD,
        S_MAX_TAKE,
        S_PUB
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = stid_pkg::CMD_NONE;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = stid_pkg::CMD_LOAD;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.at_end)
                begin
                    cmd        = stid_pkg::CMD_SCAN_MISS;
                    state_next = S_ACT;
                end
                else
                begin
                    cmd        = stid_pkg::CMD_SCAN_READ;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.less)
                begin
                    cmd        = stid_pkg::CMD_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd        = stid_pkg::CMD_SCAN_STOP;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                unique case (sts.op)
                    stid_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd        = stid_pkg::CMD_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd        = stid_pkg::CMD_INS_START;
                            state_next = S_INS_RD;
                        end
                    end
                    stid_pkg::OP_DELETE:
                    begin
                        if (sts.hit)
                        begin
                            cmd        = stid_pkg::CMD_DEL_START;
                            state_next = S_DEL_RD;
                        end
                        else
                        begin
                            cmd        = stid_pkg::CMD_MISS;
                            state_next = S_FIN;
                        end
                    end
                    stid_pkg::OP_SEARCH:
                    begin
                        if (sts.hit)
                        begin
                            cmd = stid_pkg::CMD_FOUND;
                        end
                        else
                        begin
                            cmd = stid_pkg::CMD_MISS;
                        end
                        state_next = S_FIN;
                    end
                    stid_pkg::OP_CLEAR:
                    begin
                        cmd        = stid_pkg::CMD_CLEAR;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (sts.at_pos)
                begin
                    cmd        = stid_pkg::CMD_INS_PUT;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = stid_pkg::CMD_INS_READ;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd        = stid_pkg::CMD_INS_MOVE;
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                if (sts.del_last)
                begin
                    cmd        = stid_pkg::CMD_DEL_DROP;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = stid_pkg::CMD_DEL_READ;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd        = stid_pkg::CMD_DEL_MOVE;
                state_next = S_DEL_RD;
            end
            S_FIN:
            begin
                if (sts.empty)
                begin
                    cmd        = stid_pkg::CMD_EMPTY;
                    state_next = S_PUB;
                end
                else
                begin
                    cmd        = stid_pkg::CMD_MIN_READ;
                    state_next = S_MAX_RD;
                end
            end
            S_MAX_RD:
            begin
                cmd        = stid_pkg::CMD_MAX_READ;
                state_next = S_MAX_TAKE;
            end
            S_MAX_TAKE:
            begin
                cmd        = stid_pkg::CMD_MAX_TAKE;
                state_next = S_PUB;
            end
            S_PUB:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd            = stid_pkg::CMD_PUBLISH;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef NO_ASSERTIONS
    a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == stid_pkg::CMD_PUBLISH) |-> (!rsp_valid_reg || rsp_ready))
        else $error("result published over an untaken result");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_SCAN_RD))
        else $error("accepted request did not start the scan");
`endif

endmodule

>>> hdl/sorted_table_insert_delete_search_core.sv
// Sequence: every request first scans for the lower bound; an insert that is not full
//   or a delete that hits then shifts the entries behind that position. Clear and full
//   insert still scan.
// Throughput: one operation at a time; the next request transfers once the previous
//   result sits in the output register.
// Reset: rst_n asynchronous, active low; empties the table, no result pending.
`timescale 1ns / 1ps

module sorted_table_insert_delete_search_core (
    input  logic       clk,
    input  logic       rst_n,
    stid_req_if.sink   req,
    stid_rsp_if.source rsp
);

    // Command and status between the sequencer and the table datapath
    stid_pkg::cmd_t       cmd;
    stid_pkg::dp_status_t sts;

    // Sequencer: scan for the lower bound one entry at a time (read, then compare),
    // then shift entries one at a time (read, then write), then read the first and last
    // entries for min and max (zero when empty), and finally load the output register.
    stid_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: holds the table RAM, fill count, scan index and result registers.
    // Entries at or above the fill count are never read.
    stid_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_opcode   (req.opcode),
        .in_value    (req.value),
        .sts         (sts),
        .found_index (rsp.found_index),
        .status      (rsp.status),
        .entry_count (rsp.entry_count),
        .min_value   (rsp.min_value),
        .max_value   (rsp.max_value)
    );

endmodule
